>>> hdl/zcpm_pkg.sv
// ----------------------------------------------------------------------------
// zcpm_pkg: shared types and constants of the zero-crossing phase meter
// item and result layouts, register indexes, status codes, sequencer steps
// ----------------------------------------------------------------------------
package zcpm_pkg;

  localparam int SAMPLE_BITS    = 14;
  localparam int OUT_BITS       = 16;
  localparam int REG_INDEX_BITS = 2;
  localparam int REG_DATA_BITS  = 16;
  localparam int TURN_BITS      = 16;

  // register indexes of the write port
  localparam logic [REG_INDEX_BITS-1:0] REG_ZERO_LEVEL     = 2'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_HIGH_LEVEL     = 2'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_MISMATCH_LIMIT = 2'd2;

  localparam logic [SAMPLE_BITS-1:0] ZERO_LEVEL_RESET     = SAMPLE_BITS'(0);
  localparam logic [SAMPLE_BITS-1:0] HIGH_LEVEL_RESET     = SAMPLE_BITS'(4959);
  localparam logic [OUT_BITS-1:0]    MISMATCH_LIMIT_RESET = OUT_BITS'(65535);

  // one full turn and one half turn in centidegrees
  localparam logic [TURN_BITS-1:0] TURN_CENTIDEG      = TURN_BITS'(36000);
  localparam logic [TURN_BITS-1:0] HALF_TURN_CENTIDEG = TURN_BITS'(18000);

  // item kinds
  localparam logic FUNC_TICK   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BOTH_MISSING = 3'd1,
    ST_TEST_MISSING = 3'd2,
    ST_REF_MISSING  = 3'd3,
    ST_MISMATCH     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    STEP_IDLE = 3'd0,
    STEP_ARM  = 3'd1,
    STEP_RISE = 3'd2,
    STEP_FALL = 3'd3,
    STEP_CALC = 3'd4
  } step_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_FIN
  } back_state_t;

  typedef struct packed {
    logic                   func;
    logic [SAMPLE_BITS-1:0] sample_test;
    logic [SAMPLE_BITS-1:0] sample_ref;
  } in_item_t;

  typedef struct packed {
    status_t                     status;
    logic                        phase_valid;
    logic signed [OUT_BITS-1:0]  phase_centideg;
    logic [OUT_BITS-1:0]         half_period_test;
    logic [OUT_BITS-1:0]         half_period_ref;
  } out_item_t;

  // classified item passed from front to back
  typedef struct packed {
    logic is_sample;
    logic low_test;
    logic low_ref;
    logic high_both;
  } cls_item_t;

endpackage

>>> hdl/zcpm_fifo.sv
// ----------------------------------------------------------------------------
// zcpm_fifo: small register queue
// first-word-fall-through queue of a few entries, push/full and pop/empty
// ----------------------------------------------------------------------------
module zcpm_fifo #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == CW'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

>>> hdl/zcpm_front.sv
// ----------------------------------------------------------------------------
// zcpm_front: item classifier
// sorts ticks from samples and reduces a sample pair to its level flags
// ----------------------------------------------------------------------------
module zcpm_front (
  input  zcpm_pkg::in_item_t                 item,
  input  logic [zcpm_pkg::SAMPLE_BITS-1:0]   zero_level,
  input  logic [zcpm_pkg::SAMPLE_BITS-1:0]   high_level,
  output zcpm_pkg::cls_item_t                cls
);

  always_comb begin
    cls.is_sample = (item.func == zcpm_pkg::FUNC_SAMPLE);
    cls.low_test  = (item.sample_test <= zero_level);
    cls.low_ref   = (item.sample_ref <= zero_level);
    cls.high_both = (item.sample_test > high_level) && (item.sample_ref > high_level);
  end

endmodule

>>> hdl/zcpm_back.sv
// ----------------------------------------------------------------------------
// zcpm_back: counters, half-period latches, sequencer and phase unit
// executes classified items; the phase is one multiply and a bit-serial divide
// ----------------------------------------------------------------------------
module zcpm_back #(
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  zcpm_pkg::cls_item_t               head,
  input  logic                              head_empty,
  output logic                              head_pop,
  input  logic [zcpm_pkg::OUT_BITS-1:0]     mismatch_limit,
  input  logic                              res_full,
  output logic                              res_push,
  output zcpm_pkg::out_item_t               res
);

  localparam int CB    = COUNT_BITS;
  localparam int HB    = CB - 1;
  localparam int NW    = HB + zcpm_pkg::TURN_BITS;
  localparam int CNT_W = $clog2(NW + 1);
  localparam int WIDE  = (CB > zcpm_pkg::OUT_BITS) ? CB : zcpm_pkg::OUT_BITS;
  localparam int OB    = zcpm_pkg::OUT_BITS;

  // architectural state
  logic run_test, run_ref, run_span;
  logic run_test_next, run_ref_next, run_span_next;
  logic [CB-1:0] count_test, count_ref, count_span;
  logic [CB-1:0] count_test_next, count_ref_next, count_span_next;
  logic [CB-1:0] latched_test, latched_ref;
  logic [CB-1:0] latched_test_next, latched_ref_next;
  logic [HB-1:0] span_half, span_half_next;
  logic [OB-1:0] last_phase, last_phase_next;
  zcpm_pkg::step_t       phase_step, phase_step_next;
  zcpm_pkg::back_state_t state, state_next;

  // phase unit
  logic             neg, neg_next;
  logic [HB-1:0]    mag, mag_next;
  logic [NW-1:0]    num, num_next;
  logic [CB-1:0]    rem, rem_next;
  logic [OB-1:0]    modv, modv_next;
  logic [CNT_W-1:0] div_cnt, div_cnt_next;

  // sample path
  logic run_test_upd, run_ref_upd;
  logic [CB-1:0] count_test_upd, count_ref_upd;
  logic [CB-1:0] latched_test_upd, latched_ref_upd;
  logic [CB-1:0] diff;
  zcpm_pkg::status_t status_s;
  logic [CB-1:0] d_raw;

  // divide step
  logic [CB:0]   rem_sh, rem_sub;
  logic          ge;
  logic [OB:0]   mod_sh;
  logic [OB:0]   wrap;
  logic [OB:0]   phase_full;

  // channel update on a sample
  always_comb begin
    run_test_upd     = run_test;
    count_test_upd   = count_test;
    latched_test_upd = latched_test;
    if (!head.low_test && !run_test) begin
      run_test_upd = 1'b1;
    end else if (head.low_test && run_test) begin
      latched_test_upd = count_test;
      run_test_upd     = 1'b0;
    end else if (head.low_test && !run_test) begin
      count_test_upd = '0;
    end

    run_ref_upd     = run_ref;
    count_ref_upd   = count_ref;
    latched_ref_upd = latched_ref;
    if (!head.low_ref && !run_ref) begin
      run_ref_upd = 1'b1;
    end else if (head.low_ref && run_ref) begin
      latched_ref_upd = count_ref;
      run_ref_upd     = 1'b0;
    end else if (head.low_ref && !run_ref) begin
      count_ref_upd = '0;
    end
  end

  // validity check on the updated half periods
  always_comb begin
    diff = (latched_ref_upd > latched_test_upd) ? latched_ref_upd - latched_test_upd
                                                : latched_test_upd - latched_ref_upd;
    if (latched_test_upd == '0 && latched_ref_upd == '0) begin
      status_s = zcpm_pkg::ST_BOTH_MISSING;
    end else if (latched_test_upd == '0) begin
      status_s = zcpm_pkg::ST_TEST_MISSING;
    end else if (latched_ref_upd == '0) begin
      status_s = zcpm_pkg::ST_REF_MISSING;
    end else if (WIDE'(diff) > WIDE'(mismatch_limit)) begin
      status_s = zcpm_pkg::ST_MISMATCH;
    end else begin
      status_s = zcpm_pkg::ST_OK;
    end
  end

  // signed offset of the span midpoint from the test half-period midpoint
  assign d_raw = {1'b0, span_half} - {1'b0, latched_test_upd[CB-1:1]};

  // restoring divide by the test half period, quotient reduced mod one turn
  assign rem_sh  = {rem, num[NW-1]};
  assign rem_sub = rem_sh - {1'b0, latched_test};
  assign ge      = (rem_sh >= {1'b0, latched_test});
  assign mod_sh  = {modv, ge};

  assign wrap = (modv > zcpm_pkg::HALF_TURN_CENTIDEG)
              ? {1'b0, modv} - {1'b0, zcpm_pkg::TURN_CENTIDEG}
              : {1'b0, modv};
  assign phase_full = neg ? -wrap : wrap;

  always_comb begin
    run_test_next     = run_test;
    run_ref_next      = run_ref;
    run_span_next     = run_span;
    count_test_next   = count_test;
    count_ref_next    = count_ref;
    count_span_next   = count_span;
    latched_test_next = latched_test;
    latched_ref_next  = latched_ref;
    span_half_next    = span_half;
    last_phase_next   = last_phase;
    phase_step_next   = phase_step;
    state_next        = state;
    neg_next          = neg;
    mag_next          = mag;
    num_next          = num;
    rem_next          = rem;
    modv_next         = modv;
    div_cnt_next      = div_cnt;
    head_pop          = 1'b0;
    res_push          = 1'b0;
    res.status        = status_s;
    res.phase_valid   = 1'b0;

    unique case (state)
      zcpm_pkg::BK_IDLE: begin
        if (!head_empty) begin
          if (!head.is_sample) begin
            head_pop = 1'b1;
            if (run_test) begin
              count_test_next = count_test + CB'(1);
            end
            if (run_ref) begin
              count_ref_next = count_ref + CB'(1);
            end
            if (run_span) begin
              count_span_next = count_span + CB'(1);
            end
          end else if (!res_full) begin
            head_pop          = 1'b1;
            run_test_next     = run_test_upd;
            count_test_next   = count_test_upd;
            latched_test_next = latched_test_upd;
            run_ref_next      = run_ref_upd;
            count_ref_next    = count_ref_upd;
            latched_ref_next  = latched_ref_upd;
            res_push          = 1'b1;
            if (status_s == zcpm_pkg::ST_OK) begin
              unique case (phase_step)
                zcpm_pkg::STEP_ARM: begin
                  if (!head.low_test || !head.low_ref) begin
                    phase_step_next = zcpm_pkg::STEP_RISE;
                    run_span_next   = 1'b1;
                  end
                end
                zcpm_pkg::STEP_RISE: begin
                  if (head.high_both) begin
                    phase_step_next = zcpm_pkg::STEP_FALL;
                  end
                end
                zcpm_pkg::STEP_FALL: begin
                  if (head.low_test && head.low_ref) begin
                    run_span_next   = 1'b0;
                    span_half_next  = count_span[CB-1:1];
                    phase_step_next = zcpm_pkg::STEP_CALC;
                  end
                end
                zcpm_pkg::STEP_CALC: begin
                  // result goes out once the phase unit finishes
                  res_push        = 1'b0;
                  count_span_next = '0;
                  phase_step_next = zcpm_pkg::STEP_IDLE;
                  neg_next        = d_raw[CB-1];
                  mag_next        = d_raw[CB-1] ? HB'(-d_raw) : HB'(d_raw);
                  state_next      = zcpm_pkg::BK_MUL;
                end
                default: begin
                  // idle and unused step codes
                  phase_step_next = (head.low_test && head.low_ref) ? zcpm_pkg::STEP_ARM
                                                                    : zcpm_pkg::STEP_IDLE;
                end
              endcase
            end
          end
        end
      end
      zcpm_pkg::BK_MUL: begin
        num_next     = NW'(mag) * NW'(zcpm_pkg::TURN_CENTIDEG);
        rem_next     = '0;
        modv_next    = '0;
        div_cnt_next = '0;
        state_next   = zcpm_pkg::BK_DIV;
      end
      zcpm_pkg::BK_DIV: begin
        rem_next     = ge ? rem_sub[CB-1:0] : rem_sh[CB-1:0];
        num_next     = {num[NW-2:0], 1'b0};
        modv_next    = (mod_sh >= {1'b0, zcpm_pkg::TURN_CENTIDEG})
                     ? OB'(mod_sh - {1'b0, zcpm_pkg::TURN_CENTIDEG})
                     : mod_sh[OB-1:0];
        div_cnt_next = div_cnt + CNT_W'(1);
        if (div_cnt == CNT_W'(NW - 1)) begin
          state_next = zcpm_pkg::BK_FIN;
        end
      end
      zcpm_pkg::BK_FIN: begin
        last_phase_next = phase_full[OB-1:0];
        res_push        = 1'b1;
        res.status      = zcpm_pkg::ST_OK;
        res.phase_valid = 1'b1;
        state_next      = zcpm_pkg::BK_IDLE;
      end
      default: begin
        state_next = zcpm_pkg::BK_IDLE;
      end
    endcase

    res.phase_centideg   = last_phase_next;
    res.half_period_test = OB'(latched_test_next);
    res.half_period_ref  = OB'(latched_ref_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_test     <= 1'b0;
      run_ref      <= 1'b0;
      run_span     <= 1'b0;
      count_test   <= '0;
      count_ref    <= '0;
      count_span   <= '0;
      latched_test <= '0;
      latched_ref  <= '0;
      span_half    <= '0;
      last_phase   <= '0;
      phase_step   <= zcpm_pkg::STEP_IDLE;
      state        <= zcpm_pkg::BK_IDLE;
    end else begin
      run_test     <= run_test_next;
      run_ref      <= run_ref_next;
      run_span     <= run_span_next;
      count_test   <= count_test_next;
      count_ref    <= count_ref_next;
      count_span   <= count_span_next;
      latched_test <= latched_test_next;
      latched_ref  <= latched_ref_next;
      span_half    <= span_half_next;
      last_phase   <= last_phase_next;
      phase_step   <= phase_step_next;
      state        <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    neg     <= neg_next;
    mag     <= mag_next;
    num     <= num_next;
    rem     <= rem_next;
    modv    <= modv_next;
    div_cnt <= div_cnt_next;
  end

endmodule

>>> hdl/two_channel_zero_crossing_phase_meter.sv
// ----------------------------------------------------------------------------
// two_channel_zero_crossing_phase_meter: top level
// times the high halves of a test and a reference channel and reports their
// phase difference in centidegrees
// ----------------------------------------------------------------------------
//
//  channel  side  handshake        payload
//  item     in    push / full      zcpm_pkg::in_item_t  (tick or sample pair)
//  result   out   pop / empty      zcpm_pkg::out_item_t (one per sample)
//  config   in    write_en         write_index, write_data
//
//  a tick or a sample is registered in the input queue and executed by the back
//  end; a sample that completes a phase measurement then runs the multiply and
//  the bit-serial divider (one quotient bit a cycle) before its result goes out
//  synchronous reset returns counters, latches, sequencer state, configuration
//  and queue pointers to defaults, not the phase unit registers; the two-entry
//  input queue takes items while the back end works; a sample waits at the queue
//  head while the two-entry result queue is full
module two_channel_zero_crossing_phase_meter #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // item side
  input  logic                                  push,
  output logic                                  full,
  input  zcpm_pkg::in_item_t                    item,
  // result side
  output logic                                  empty,
  input  logic                                  pop,
  output zcpm_pkg::out_item_t                   result,
  // register writes
  input  logic                                  write_en,
  input  logic [zcpm_pkg::REG_INDEX_BITS-1:0]   write_index,
  input  logic [zcpm_pkg::REG_DATA_BITS-1:0]    write_data
);

  // configuration registers
  logic [zcpm_pkg::SAMPLE_BITS-1:0] zero_level;
  logic [zcpm_pkg::SAMPLE_BITS-1:0] high_level;
  logic [zcpm_pkg::OUT_BITS-1:0]    mismatch_limit;

  // front to back queue
  zcpm_pkg::cls_item_t cls_in;
  zcpm_pkg::cls_item_t cls_head;
  logic                cls_empty;
  logic                cls_pop;

  // back to result queue
  zcpm_pkg::out_item_t res_item;
  logic                res_push;
  logic                res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_level     <= zcpm_pkg::ZERO_LEVEL_RESET;
      high_level     <= zcpm_pkg::HIGH_LEVEL_RESET;
      mismatch_limit <= zcpm_pkg::MISMATCH_LIMIT_RESET;
    end else if (write_en) begin
      unique case (write_index)
        zcpm_pkg::REG_ZERO_LEVEL:     zero_level     <= write_data[zcpm_pkg::SAMPLE_BITS-1:0];
        zcpm_pkg::REG_HIGH_LEVEL:     high_level     <= write_data[zcpm_pkg::SAMPLE_BITS-1:0];
        zcpm_pkg::REG_MISMATCH_LIMIT: mismatch_limit <= write_data[zcpm_pkg::OUT_BITS-1:0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // level compares against the thresholds
  zcpm_front u_front (
    .item       (item),
    .zero_level (zero_level),
    .high_level (high_level),
    .cls        (cls_in)
  );

  // classified items wait here while the back end is busy
  zcpm_fifo #(
    .WIDTH ($bits(zcpm_pkg::cls_item_t)),
    .DEPTH (2)
  ) u_cls_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .din   (cls_in),
    .pop   (cls_pop),
    .empty (cls_empty),
    .dout  (cls_head)
  );

  // counters, sequencer and phase unit
  zcpm_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (cls_head),
    .head_empty     (cls_empty),
    .head_pop       (cls_pop),
    .mismatch_limit (mismatch_limit),
    .res_full       (res_full),
    .res_push       (res_push),
    .res            (res_item)
  );

  // finished results wait here for the consumer
  zcpm_fifo #(
    .WIDTH ($bits(zcpm_pkg::out_item_t)),
    .DEPTH (2)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .din   (res_item),
    .pop   (pop),
    .empty (empty),
    .dout  (result)
  );

endmodule

>>> hdl/zcpm_checker.sv
// ----------------------------------------------------------------------------
// zcpm_checker: port-level checks of the phase meter
// watches the queue handshakes and result fields, attached by bind
// ----------------------------------------------------------------------------
module zcpm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                full,
  input logic                                empty,
  input logic                                pop,
  input zcpm_pkg::out_item_t                 result
);

  // reset leaves both queues empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("queues not empty after reset");

  // a waiting result is not withdrawn
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty)
    else $error("waiting result vanished");

  // a fresh phase only comes with a good status
  a_valid_ok: assert property (@(posedge clk) disable iff (rst)
    !empty && result.phase_valid |-> result.status == zcpm_pkg::ST_OK)
    else $error("phase reported with bad status");

  // phase stays within one half turn either way
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> $signed(result.phase_centideg) >= -16'sd18000 &&
               $signed(result.phase_centideg) <= 16'sd18000)
    else $error("phase out of range");

  // both missing means both half periods read zero
  a_missing: assert property (@(posedge clk) disable iff (rst)
    !empty && result.status == zcpm_pkg::ST_BOTH_MISSING |->
      result.half_period_test == '0 && result.half_period_ref == '0)
    else $error("missing status with nonzero half period");

endmodule

bind two_channel_zero_crossing_phase_meter zcpm_checker u_zcpm_checker (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .result      (result)
);

>>> bench/two_channel_zero_crossing_phase_meter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_channel_zero_crossing_phase_meter_tb: self-checking bench of the phase meter
// feeds ticks and sample pairs through the item queue, predicts every reading
// of the meter in step with the accepted items and compares each field as
// the reading leaves the result queue
// ----------------------------------------------------------------------------
module two_channel_zero_crossing_phase_meter_tb;
  import zcpm_pkg::*;

  localparam int COUNT_BITS   = 16;
  localparam int SAMPLE_MAX   = 16383;
  localparam int IN_BITS      = $bits(in_item_t);
  // a phase result waits for the multiply and the divider; ticks have no reading to wait for
  localparam int DRAIN_CYCLES = COUNT_BITS + 30;
  localparam int HOLD_CYCLES  = 400;
  localparam int REPORT_MAX   = 10;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      push = 1'b0;
  logic                      full;
  in_item_t                  item = '0;
  logic                      empty;
  logic                      pop = 1'b0;
  out_item_t                 result;
  logic                      write_en = 1'b0;
  logic [REG_INDEX_BITS-1:0] write_index = '0;
  logic [REG_DATA_BITS-1:0]  write_data = '0;

  two_channel_zero_crossing_phase_meter #(
    .COUNT_BITS(COUNT_BITS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .empty      (empty),
    .pop        (pop),
    .result     (result),
    .write_en   (write_en),
    .write_index(write_index),
    .write_data (write_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // meter model state, mirrors the block from reset on
  // --------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] cfg_zero  = ZERO_LEVEL_RESET;
  logic [SAMPLE_BITS-1:0] cfg_high  = HIGH_LEVEL_RESET;
  logic [OUT_BITS-1:0]    cfg_limit = MISMATCH_LIMIT_RESET;

  logic                       test_running = 1'b0;
  logic                       ref_running  = 1'b0;
  logic                       span_running = 1'b0;
  logic [OUT_BITS-1:0]        test_count   = '0;
  logic [OUT_BITS-1:0]        ref_count    = '0;
  logic [OUT_BITS-1:0]        span_count   = '0;
  logic [OUT_BITS-1:0]        test_half    = '0;
  logic [OUT_BITS-1:0]        ref_half     = '0;
  logic [OUT_BITS-1:0]        span_mid     = '0;
  step_t                      seq_step     = STEP_IDLE;
  logic signed [OUT_BITS-1:0] phase_last   = '0;

  // readings predicted for accepted samples, oldest first
  out_item_t pending_readings[$];

  // run bookkeeping
  int   items_sent       = 0;
  int   ticks_sent       = 0;
  int   readings_checked = 0;
  int   phases_done      = 0;
  int   mismatches       = 0;
  int   unexpected       = 0;
  int   reported         = 0;
  bit [4:0] status_seen  = '0;

  // idling control shared by the tests and the two sides
  bit sender_gaps_on = 1'b1;
  bit hold_request   = 1'b0;
  int send_calm      = 0;
  int recv_calm      = 0;

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  // phase in centidegrees from half the span and the test half period,
  // truncated toward zero, folded by whole turns into [-18000, 18000]
  function automatic logic signed [OUT_BITS-1:0] phase_of(input logic [OUT_BITS-1:0] mid,
                                                         input logic [OUT_BITS-1:0] half);
    longint num, den, turn, half_turn, q, r;
    if (half == '0) return '0;
    num       = longint'(mid);
    den       = longint'(half);
    turn      = longint'(TURN_CENTIDEG);
    half_turn = longint'(HALF_TURN_CENTIDEG);
    num       = num - den / 2;
    q         = (num * turn) / den;
    r         = q % turn;
    if (r > half_turn) r = r - turn;
    if (r < -half_turn) r = r + turn;
    return r[OUT_BITS-1:0];
  endfunction

  // high-time tracking of one channel on a sample
  task automatic track_channel(input logic low, inout logic running,
                               inout logic [OUT_BITS-1:0] count,
                               inout logic [OUT_BITS-1:0] half);
    if (!low && !running) begin
      running = 1'b1;
    end else if (low && running) begin
      half    = count;
      running = 1'b0;
    end else if (low && !running) begin
      count = '0;
    end
  endtask

  // advance the meter model by one accepted item, queue the reading it gives
  task automatic advance_meter(input in_item_t it);
    logic                low_t, low_r;
    logic [OUT_BITS-1:0] half_diff;
    status_t             st;
    logic                fresh;
    out_item_t           r;
    if (it.func == FUNC_TICK) begin
      // counters wrap at the counter width
      if (test_running) test_count++;
      if (ref_running) ref_count++;
      if (span_running) span_count++;
      return;
    end
    low_t = it.sample_test <= cfg_zero;
    low_r = it.sample_ref <= cfg_zero;
    track_channel(low_t, test_running, test_count, test_half);
    track_channel(low_r, ref_running, ref_count, ref_half);

    half_diff = (ref_half > test_half) ? ref_half - test_half : test_half - ref_half;
    if (test_half == '0 && ref_half == '0) st = ST_BOTH_MISSING;
    else if (test_half == '0) st = ST_TEST_MISSING;
    else if (ref_half == '0) st = ST_REF_MISSING;
    else if (half_diff > cfg_limit) st = ST_MISMATCH;
    else st = ST_OK;

    // the sequencer only moves while both half periods are valid
    fresh = 1'b0;
    if (st == ST_OK) begin
      case (seq_step)
        STEP_ARM: begin
          if (!low_t || !low_r) begin
            seq_step     = STEP_RISE;
            span_running = 1'b1;
          end
        end
        STEP_RISE: begin
          if (it.sample_test > cfg_high && it.sample_ref > cfg_high) seq_step = STEP_FALL;
        end
        STEP_FALL: begin
          if (low_t && low_r) begin
            span_running = 1'b0;
            span_mid     = span_count >> 1;
            seq_step     = STEP_CALC;
          end
        end
        STEP_CALC: begin
          span_count = '0;
          phase_last = phase_of(span_mid, test_half);
          fresh      = 1'b1;
          seq_step   = STEP_IDLE;
          phases_done++;
        end
        default: begin
          if (low_t && low_r) seq_step = STEP_ARM;
          else seq_step = STEP_IDLE;
        end
      endcase
    end

    r.status           = st;
    r.phase_valid      = fresh;
    r.phase_centideg   = phase_last;
    r.half_period_test = test_half;
    r.half_period_ref  = ref_half;
    status_seen[st]    = 1'b1;
    pending_readings.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // idling: mostly short gaps, a few long ones, now and then a calm stretch
  // --------------------------------------------------------------------------
  function automatic int gap_len(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(99, 0);
    if (roll < 2) begin
      calm = $urandom_range(60, 20);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // --------------------------------------------------------------------------
  // item side
  // --------------------------------------------------------------------------

  // offer one item, hold it until the queue takes it, then predict
  task automatic send_item(input in_item_t it);
    int gap;
    gap = sender_gaps_on ? gap_len(send_calm) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // push stays high from one item to the next when there is no gap
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full !== 1'b0);
    advance_meter(it);
    items_sent++;
    if (it.func == FUNC_TICK) ticks_sent++;
  endtask

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] st,
                             input logic [SAMPLE_BITS-1:0] sr);
    in_item_t it;
    it.func        = FUNC_SAMPLE;
    it.sample_test = st;
    it.sample_ref  = sr;
    send_item(it);
  endtask

  // ticks carry random sample bits, which the meter ignores
  task automatic send_ticks(input int n);
    in_item_t it;
    repeat (n) begin
      it             = IN_BITS'($urandom);
      it.func        = FUNC_TICK;
      send_item(it);
    end
  endtask

  // sample value for a channel level under the current thresholds
  function automatic logic [SAMPLE_BITS-1:0] level_value(input bit hi);
    if (!hi) return SAMPLE_BITS'($urandom_range(cfg_zero, 0));
    // mostly fully risen, sometimes only above the zero level
    if ($urandom_range(99, 0) < 85 || cfg_high <= cfg_zero) begin
      if (cfg_high == SAMPLE_BITS'(SAMPLE_MAX)) return SAMPLE_BITS'(SAMPLE_MAX);
      return SAMPLE_BITS'($urandom_range(SAMPLE_MAX, int'(cfg_high) + 1));
    end
    return SAMPLE_BITS'($urandom_range(cfg_high, int'(cfg_zero) + 1));
  endfunction

  function automatic int pick_half(input int max_half);
    if ($urandom_range(9, 0) < 9) return $urandom_range(12, 1);
    return $urandom_range(max_half, 1);
  endfunction

  // square-ish waves on both channels: one sample per time step with a tick
  // (rarely none or a few) in between, random high times and lead/lag
  task automatic run_waves(input int n_items, input int max_half);
    int start, ht, hr, off_t, off_r, len, s, ticks, roll;
    bit hi_t, hi_r;
    start = items_sent;
    while (items_sent - start < n_items) begin
      ht = pick_half(max_half);
      hr = ($urandom_range(9, 0) < 6) ? ht : pick_half(max_half);
      if ($urandom_range(1, 0) == 1) begin
        off_t = 0;
        off_r = $urandom_range(ht, 0);
      end else begin
        off_r = 0;
        off_t = $urandom_range(hr, 0);
      end
      len = (off_t + ht > off_r + hr) ? off_t + ht : off_r + hr;
      len = len + $urandom_range(6, 1);
      for (s = 0; s < len; s++) begin
        hi_t = (s >= off_t) && (s < off_t + ht);
        hi_r = (s >= off_r) && (s < off_r + hr);
        send_sample(level_value(hi_t), level_value(hi_r));
        roll = $urandom_range(99, 0);
        if (roll < 80) ticks = 1;
        else if (roll < 90) ticks = 0;
        else ticks = $urandom_range(4, 2);
        send_ticks(ticks);
      end
    end
  endtask

  // lower push and let every predicted reading come out, then drain
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // all three threshold registers, written back to back while idle
  task automatic set_config(input logic [SAMPLE_BITS-1:0] zero_lvl,
                            input logic [SAMPLE_BITS-1:0] high_lvl,
                            input logic [OUT_BITS-1:0] limit);
    wait_idle();
    write_en    <= 1'b1;
    write_index <= REG_ZERO_LEVEL;
    write_data  <= REG_DATA_BITS'(zero_lvl);
    @(posedge clk);
    write_index <= REG_HIGH_LEVEL;
    write_data  <= REG_DATA_BITS'(high_lvl);
    @(posedge clk);
    write_index <= REG_MISMATCH_LIMIT;
    write_data  <= limit;
    @(posedge clk);
    write_en    <= 1'b0;
    cfg_zero  = zero_lvl;
    cfg_high  = high_lvl;
    cfg_limit = limit;
  endtask

  // --------------------------------------------------------------------------
  // result side: random pop with stalls, long hold-off on request
  // --------------------------------------------------------------------------
  task automatic check_reading(input out_item_t got);
    out_item_t want;
    if (pending_readings.size() == 0) begin
      unexpected++;
      if (reported < REPORT_MAX) begin
        reported++;
        $display("unexpected reading st=%0d v=%0b ph=%0d ht=%0d hr=%0d", got.status,
                 got.phase_valid, got.phase_centideg, got.half_period_test,
                 got.half_period_ref);
      end
      return;
    end
    want = pending_readings.pop_front();
    readings_checked++;
    if (got.status !== want.status || got.phase_valid !== want.phase_valid ||
        got.phase_centideg !== want.phase_centideg ||
        got.half_period_test !== want.half_period_test ||
        got.half_period_ref !== want.half_period_ref) begin
      mismatches++;
      if (reported < REPORT_MAX) begin
        reported++;
        $display("reading %0d: exp st=%0d v=%0b ph=%0d ht=%0d hr=%0d", readings_checked,
                 want.status, want.phase_valid, want.phase_centideg,
                 want.half_period_test, want.half_period_ref);
        $display("reading %0d: got st=%0d v=%0b ph=%0d ht=%0d hr=%0d", readings_checked,
                 got.status, got.phase_valid, got.phase_centideg,
                 got.half_period_test, got.half_period_ref);
      end
    end
  endtask

  initial begin : reading_side
    int stall;
    int hold;
    stall = 0;
    hold  = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (pop && !empty) check_reading(result);
      if (hold_request) begin
        hold_request = 1'b0;
        hold         = HOLD_CYCLES;
      end
      // one pop assignment per edge
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        pop   <= 1'b1;
        stall = gap_len(recv_calm);
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // hand-built run at reset thresholds: both missing, reference missing,
  // sequencer arming, the fully risen boundary, a phase result, and a
  // zero-length high time giving a missing test channel
  task automatic test_directed_sequence();
    send_sample(14'd0, 14'd0);
    send_ticks(1);
    send_sample(14'h3FFF, 14'd0);
    send_ticks(3);
    send_sample(14'd0, 14'd0);
    send_sample(14'd0, 14'h3FFF);
    send_ticks(2);
    send_sample(14'd0, 14'd0);
    send_sample(14'd1, 14'h3FFF);
    send_ticks(3);
    // exactly at the high level is not fully risen, one above is
    send_sample(14'd4959, 14'h3FFF);
    send_sample(14'd4960, 14'd4960);
    send_ticks(1);
    send_sample(14'd0, 14'd0);
    send_sample(14'd0, 14'd0);
    // high for no ticks at all latches a zero test half period
    send_sample(14'h3FFF, 14'd0);
    send_sample(14'd0, 14'd0);
    send_sample(14'h2AAA, 14'h1555);
    send_sample(14'h1555, 14'h2AAA);
  endtask

  task automatic test_default_waves();
    run_waves(250, 40);
  endtask

  // thresholds moved up so low samples are no longer only zero
  task automatic test_raised_levels();
    set_config(SAMPLE_BITS'($urandom_range(3000, 1000)),
               SAMPLE_BITS'($urandom_range(11000, 8000)), 16'hFFFF);
    run_waves(200, 40);
  endtask

  // tight mismatch limits: equal halves only, then a small tolerance
  task automatic test_period_mismatch();
    set_config(ZERO_LEVEL_RESET, HIGH_LEVEL_RESET, 16'd0);
    run_waves(100, 20);
    set_config(ZERO_LEVEL_RESET, HIGH_LEVEL_RESET, 16'd2);
    run_waves(100, 20);
  endtask

  // reading side stops long enough for both queues to fill and full to rise
  task automatic test_receiver_hold_off();
    set_config(ZERO_LEVEL_RESET, HIGH_LEVEL_RESET, MISMATCH_LIMIT_RESET);
    sender_gaps_on = 1'b0;
    hold_request   = 1'b1;
    run_waves(150, 20);
    sender_gaps_on = 1'b1;
  endtask

  // unshaped items under random thresholds, half of the samples pulled low
  task automatic test_noise();
    in_item_t it;
    logic [$bits(in_item_t)-1:0] raw;
    int zero_lvl;
    int n;
    zero_lvl = $urandom_range(3000, 0);
    set_config(SAMPLE_BITS'(zero_lvl),
               SAMPLE_BITS'($urandom_range(12000, zero_lvl)),
               OUT_BITS'($urandom_range(65535, 0)));
    for (n = 0; n < 150; n++) begin
      raw = IN_BITS'($urandom);
      it  = raw;
      if ($urandom_range(1, 0) == 1) it.sample_test = SAMPLE_BITS'($urandom_range(zero_lvl, 0));
      if ($urandom_range(1, 0) == 1) it.sample_ref = SAMPLE_BITS'($urandom_range(zero_lvl, 0));
      send_item(it);
    end
  endtask

  // threshold extremes: everything low, everything risen, nothing fully risen
  task automatic test_level_extremes();
    set_config(14'h3FFF, 14'h3FFF, 16'd0);
    run_waves(30, 12);
    set_config(14'd0, 14'd0, 16'hFFFF);
    run_waves(100, 20);
    set_config(14'd0, 14'h3FFF, 16'hFFFF);
    run_waves(60, 12);
  endtask

  // one long high time on both channels, the test channel stays high longer
  // so both half periods latch well above eight bits
  task automatic test_long_high_time();
    set_config(ZERO_LEVEL_RESET, HIGH_LEVEL_RESET, MISMATCH_LIMIT_RESET);
    sender_gaps_on = 1'b0;
    send_sample(14'd0, 14'd0);
    send_sample(14'h3FFF, 14'h3FFF);
    send_ticks(300);
    send_sample(14'h3FFF, 14'd0);
    send_ticks(25);
    send_sample(14'd0, 14'd0);
    sender_gaps_on = 1'b1;
    run_waves(60, 12);
  endtask

  // --------------------------------------------------------------------------
  // run order and verdict
  // --------------------------------------------------------------------------
  initial begin : run_all
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_sequence();
    test_default_waves();
    test_raised_levels();
    test_period_mismatch();
    test_receiver_hold_off();
    test_noise();
    test_level_extremes();
    test_long_high_time();
    wait_idle();
    $display("run covered %0d items (%0d ticks), %0d readings checked, %0d phase results",
             items_sent, ticks_sent, readings_checked, phases_done);
    $display("status codes seen %b, %0d mismatching and %0d unexpected readings",
             status_seen, mismatches, unexpected);
    if (mismatches == 0 && unexpected == 0 && pending_readings.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // generous bound well above the slowest legal run
  initial begin : watchdog
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
